@@ src/aligned_bump_allocator_macros.svh @@
// assertion helpers shared by the allocator modules
`ifndef ALIGNED_BUMP_ALLOCATOR_MACROS_SVH
`define ALIGNED_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define ABA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("allocator assertion failed");

// next-cycle implication, checked out of reset
`define ABA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("allocator assertion failed");

`endif

@@ src/aba_pkg.sv @@
`timescale 1ns / 1ps

package aba_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned ALIGN_W = 16;
  localparam int unsigned INDEX_W = 2;
  localparam int unsigned STEP_W  = 5;

  localparam logic [INDEX_W-1:0] REG_BASE     = 2'd0;
  localparam logic [INDEX_W-1:0] REG_CAPACITY = 2'd1;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ALIGN,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [ALIGN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ALIGN_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ src/aba_rem_serial.sv @@
`timescale 1ns / 1ps

`include "aligned_bump_allocator_macros.svh"

module aba_rem_serial
  import aba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [ADDR_W-1:0]  dvd;
  logic [ALIGN_W-1:0] divisor;
  logic [ALIGN_W-1:0] rem;
  logic [STEP_W-1:0]  cnt;
  logic               busy;
  logic               done;

  logic [ALIGN_W:0]   trial;
  logic [ALIGN_W:0]   diff;
  logic               fits;

  // one quotient bit per cycle, remainder stays below the divisor
  assign trial = {rem, dvd[ADDR_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      dvd <= {dvd[ADDR_W-2:0], 1'b0};
      rem <= fits ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

  `ABA_ASSERT_NEXT(a_start_busy, req.start, busy)
  `ABA_ASSERT_NOW(a_rem_below_divisor, busy && !req.start, rem < divisor)
  `ABA_ASSERT_NOW(a_no_restart, req.start, !busy)

endmodule

@@ src/aligned_bump_allocator.sv @@
`timescale 1ns / 1ps
// the remainder unit shifts one dividend bit a cycle through all 32 dividend
// bits and flags done in the cycle after the last shift; the rounded offset,
// the room check, the grant and the output word are then registered in turn
// (the output word waits for a free slot); one request at a time is in flight
// reset (rst, synchronous): base, capacity and offset clear, output empties

`include "aligned_bump_allocator_macros.svh"

module aligned_bump_allocator
  import aba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_size[31:0], request_alignment[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // far_pointer[31:0], granted_offset[63:32]
  output logic [0:0]  m_tuser,   // granted[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0]  base_address;
  logic [ADDR_W-1:0]  region_capacity;
  logic [ADDR_W-1:0]  next_free_offset;
  logic [ADDR_W-1:0]  size;
  logic [ALIGN_W-1:0] align;
  logic [ADDR_W-1:0]  aligned;
  logic [ADDR_W-1:0]  avail;
  logic               over;
  logic               ok;
  logic [ADDR_W-1:0]  phys;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_xact;
  logic cfg_xact;
  logic out_free;
  logic [ALIGN_W-1:0] req_align;
  logic [ALIGN_W-1:0] pad;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xact   = s_tvalid && s_tready;
  assign cfg_xact  = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;

  // zero alignment means byte alignment
  assign req_align = (s_tdata[47:32] == '0) ? {{(ALIGN_W-1){1'b0}}, 1'b1} : s_tdata[47:32];
  assign pad       = align - div_rsp.rem;

  assign div_req.start    = in_xact;
  assign div_req.dividend = next_free_offset;
  assign div_req.divisor  = req_align;

  aba_rem_serial u_rem (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xact) state_next = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_next = ST_ALIGN;
      ST_ALIGN: state_next = ST_CHECK;
      ST_CHECK: state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xact) begin
      size  <= s_tdata[31:0];
      align <= req_align;
    end
    if (state == ST_DIV && div_rsp.done) begin
      aligned <= (div_rsp.rem == '0) ? next_free_offset
                                     : next_free_offset + {{(ADDR_W-ALIGN_W){1'b0}}, pad};
    end
    if (state == ST_ALIGN) begin
      avail <= region_capacity - aligned;
      over  <= aligned > region_capacity;
    end
    if (state == ST_CHECK) begin
      ok   <= !over && (size != '0) && (size <= avail);
      phys <= base_address + aligned;
    end
    if (state == ST_EMIT && out_free) begin
      m_tuser[0]     <= ok;
      m_tdata[15:0]  <= ok ? {12'd0, phys[3:0] & NIBBLE_MASK} : 16'd0;
      m_tdata[31:16] <= ok ? phys[19:4] : 16'd0;
      m_tdata[63:32] <= ok ? aligned : '0;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid         <= 1'b0;
      base_address     <= '0;
      region_capacity  <= '0;
      next_free_offset <= '0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_xact && (cfg_index == REG_BASE || cfg_index == REG_CAPACITY)) begin
        next_free_offset <= '0;
      end else if (state == ST_EMIT && out_free && ok) begin
        next_free_offset <= aligned + size;
      end
      if (cfg_xact) begin
        unique case (cfg_index)
          REG_BASE: begin
            base_address <= cfg_data;
          end
          REG_CAPACITY: begin
            region_capacity <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  `ABA_ASSERT_NOW(a_done_in_div, div_rsp.done, state == ST_DIV)
  `ABA_ASSERT_NEXT(a_accept_starts_div, in_xact, state == ST_DIV && div_rsp.busy)
  `ABA_ASSERT_NEXT(a_offset_held, state == ST_EMIT && !out_free && !cfg_xact,
                   $stable(next_free_offset))
  `ABA_ASSERT_NOW(a_fail_is_null, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule

@@ tb/tb_aligned_bump_allocator.sv @@
`timescale 1ns / 1ps

module tb_aligned_bump_allocator;
  import aba_pkg::*;

  localparam logic [INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [INDEX_W-1:0] REG_UNUSED_B = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CALM_FROM = 1000;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        granted;
    logic [31:0] far_pointer;
    logic [31:0] granted_offset;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [31:0]        data;
    logic [31:0]        size;
    logic [15:0]        align;
    logic               typed;
    grant_t             want;
  } stim_row_t;

  localparam grant_t NO_GRANT = '{1'b0, 32'h0, 32'h0};
  localparam int N_ROWS = 26;

  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'h1,    1'b1, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h0,         16'h0,    1'b1, NO_GRANT},
    '{ROW_CFG, REG_CAPACITY, 32'hFFFF_FFFF, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_CFG, REG_BASE,     32'hFFFF_FFFF, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h0,         16'hFFFF, 1'b1, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h10,        16'h0,    1'b1,
      '{1'b1, 32'hFFFF_000F, 32'h0}},
    '{ROW_REQ, REG_BASE,     32'h0,         32'hFFFF_FFFF, 16'h1,    1'b1, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'hFFFF_FFE0, 16'hFFFF, 1'b0, NO_GRANT},
    // physical address wraps past the top
    '{ROW_REQ, REG_BASE,     32'h0,         32'hFFFF_FFD0, 16'h10,   1'b0, NO_GRANT},
    // rounding wraps the offset to zero
    '{ROW_REQ, REG_BASE,     32'h0,         32'h20,        16'h100,  1'b0, NO_GRANT},
    '{ROW_CFG, REG_UNUSED_A, 32'h1234_5678, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_CFG, REG_UNUSED_B, 32'hFFFF_FFFF, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'h8000, 1'b0, NO_GRANT},
    '{ROW_CFG, REG_BASE,     32'h0,         32'h0,         16'h0,    1'b0, NO_GRANT},
    // grant at physical zero looks like a null pointer
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'h1,    1'b1,
      '{1'b1, 32'h0, 32'h0}},
    '{ROW_CFG, REG_CAPACITY, 32'h100,       32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h100,       16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'h1,    1'b1, NO_GRANT},
    '{ROW_CFG, REG_CAPACITY, 32'hF0,        32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h10,        16'h80,   1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'hFF,   1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h5555_5555, 16'hAAAA, 1'b0, NO_GRANT},
    '{ROW_CFG, REG_BASE,     32'h000A_BCDE, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_CFG, REG_CAPACITY, 32'hFFFF_FFFF, 32'h0,         16'h0,    1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'hAAAA_AAAA, 16'h5555, 1'b0, NO_GRANT},
    '{ROW_REQ, REG_BASE,     32'h0,         32'h1,         16'h8000, 1'b0, NO_GRANT}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [47:0]        s_tdata = '0;   // request_size[31:0], request_alignment[47:32]
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [63:0]        m_tdata;        // far_pointer[31:0], granted_offset[63:32]
  logic [0:0]         m_tuser;        // granted[0]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]  cfg_data = '0;

  logic [31:0] cfg_base = '0;
  logic [31:0] cfg_capacity = '0;
  logic [31:0] next_offset = '0;

  grant_t      grant_queue [$];
  int unsigned mismatch_count = 0;
  int unsigned n_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  logic        gaps_on = 1'b1;

  aligned_bump_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic grant_t grant_for(input logic [31:0] size, input logic [15:0] align);
    logic [31:0] step;
    logic [31:0] slack;
    logic [31:0] rounded;
    logic [31:0] phys;
    grant_t      g;
    g = NO_GRANT;
    if (size == 0) return g;
    step = (align == 0) ? 32'd1 : {16'd0, align};
    slack = next_offset % step;
    rounded = (slack == 0) ? next_offset : next_offset + (step - slack);
    if (rounded > cfg_capacity || size > cfg_capacity - rounded) return g;
    next_offset = rounded + size;
    phys = cfg_base + rounded;
    g.granted = 1'b1;
    g.far_pointer = {phys[19:4], 12'd0, phys[3:0]};
    g.granted_offset = rounded;
    return g;
  endfunction

  task automatic send_request(input logic [31:0] size, input logic [15:0] align,
                              input logic typed, input grant_t want);
    grant_t g;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tdata = {align, size};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    g = grant_for(size, align);
    grant_queue.push_back(typed ? want : g);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [INDEX_W-1:0] index, input logic [31:0] data);
    s_tvalid = 1'b0;
    while (grant_queue.size() != 0) @(negedge clk);
    cfg_index = index;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_BASE) begin
      cfg_base = data;
      next_offset = '0;
    end else if (index == REG_CAPACITY) begin
      cfg_capacity = data;
      next_offset = '0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (grant_queue.size() == 0) begin
        $display("%0t: result with none pending expected none actual %h/%h", $time,
                 m_tuser, m_tdata);
        mismatch_count++;
      end else begin
        want = grant_queue.pop_front();
        check_field("granted", {31'd0, want.granted}, {31'd0, m_tuser[0]});
        check_field("far_pointer", want.far_pointer, m_tdata[31:0]);
        check_field("granted_offset", want.granted_offset, m_tdata[63:32]);
      end
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (!gaps_on) begin
      m_tready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_aligned_bump_allocator: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned batch;
    int unsigned odd_at;
    logic [31:0] size;
    logic [15:0] align;
    logic [31:0] room;
    logic        base_first;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_register(dir_rows[i].index, dir_rows[i].data);
      end else begin
        send_request(dir_rows[i].size, dir_rows[i].align, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      gaps_on = (n_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      base_first = 1'($urandom_range(0, 1));
      repeat (2) begin
        if (base_first) begin
          case ($urandom_range(0, 3))
            0: write_register(REG_BASE, 32'h0);
            1: write_register(REG_BASE, 32'hFFFF_FFFF);
            default: write_register(REG_BASE, $urandom);
          endcase
        end else begin
          case ($urandom_range(0, 5))
            0: write_register(REG_CAPACITY, 32'h0);
            1: write_register(REG_CAPACITY, 32'hFFFF_FFFF);
            2: write_register(REG_CAPACITY, $urandom_range(1, 4096));
            3: write_register(REG_CAPACITY, $urandom_range(1, 1 << 20));
            default: write_register(REG_CAPACITY, $urandom);
          endcase
        end
        base_first = ~base_first;
      end
      batch = $urandom_range(15, 50);
      odd_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, batch - 1) : batch;
      for (int unsigned k = 0; k < batch; k++) begin
        if (k == odd_at) begin
          write_register($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
        end
        room = (next_offset <= cfg_capacity) ? cfg_capacity - next_offset : 32'd0;
        case ($urandom_range(0, 11))
          0: size = 32'h0;
          1: size = $urandom;
          2, 3: size = $urandom_range(1, 64);
          4, 5: size = $urandom_range(1, 4096);
          6: size = (room == 0) ? 32'd1 : room;
          default: size = $urandom_range(1, (cfg_capacity >> 4) + 1);
        endcase
        case ($urandom_range(0, 7))
          0: align = 16'h0;
          1: align = 16'hFFFF;
          2: align = 16'($urandom_range(1, 16));
          3: align = 16'($urandom_range(0, 16'hFFFF));
          default: align = 16'(1 << $urandom_range(0, 15));
        endcase
        send_request(size, align, 1'b0, NO_GRANT);
      end
    end

    s_tvalid = 1'b0;
    while (grant_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_aligned_bump_allocator: PASS");
    end else begin
      $display("tb_aligned_bump_allocator: FAIL");
    end
    $finish;
  end

endmodule
